@@ rtl/swc_pkg.sv @@
// Shared types, constants and lookup tables for the square wave channel.
// No dependencies; used by the divider and by the top level.
package swc_pkg;

	// Field widths
	localparam int unsigned OP_W     = 3;
	localparam int unsigned PERIOD_W = 12;
	localparam int unsigned TICKS_W  = 6;
	localparam int unsigned DVD_W    = PERIOD_W + 1;
	localparam int unsigned DIV_CNT_W = $clog2(DVD_W);

	// Operation codes
	localparam logic [OP_W-1:0] OP_REG_WRITE = 3'd0;
	localparam logic [OP_W-1:0] OP_ENABLE    = 3'd1;
	localparam logic [OP_W-1:0] OP_QUARTER   = 3'd2;
	localparam logic [OP_W-1:0] OP_HALF      = 3'd3;
	localparam logic [OP_W-1:0] OP_TICK      = 3'd4;

	// Channel register indexes
	localparam logic [1:0] REG_CTRL   = 2'd0;
	localparam logic [1:0] REG_SWEEP  = 2'd1;
	localparam logic [1:0] REG_TIMER_LO = 2'd2;
	localparam logic [1:0] REG_TIMER_HI = 2'd3;

	localparam logic [3:0]  VOL_MAX      = 4'd15;
	localparam logic [13:0] SWEEP_LIMIT  = 14'h7FF;
	localparam logic [PERIOD_W-1:0] PERIOD_MIN = 12'd8;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [1:0]         reg_index;
		logic [7:0]         write_data;
		logic               enable_bit;
		logic [TICKS_W-1:0] sample_ticks;
	} in_item_t;

	typedef struct packed {
		logic [3:0] dac_level;
		logic       length_active;
	} out_item_t;

	localparam logic [7:0] LENGTH_TABLE [32] = '{
		8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
		8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
		8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
		8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
	};

	// Duty waveform: bit n of the pattern is sequencer step n
	function automatic logic duty_bit(input logic [1:0] mode, input logic [2:0] step);
		logic [7:0] pattern;
		case (mode)
			2'd0:    pattern = 8'b0000_0010;
			2'd1:    pattern = 8'b0000_0110;
			2'd2:    pattern = 8'b0001_1110;
			default: pattern = 8'b1111_1001;
		endcase
		return pattern[step];
	endfunction

endpackage

@@ rtl/swc_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on swc_pkg for widths.
module swc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [swc_pkg::DVD_W-1:0]     dividend,
	input  logic [swc_pkg::PERIOD_W-1:0]  divisor,
	output logic                          done,
	output logic [swc_pkg::DVD_W-1:0]     quotient,
	output logic [swc_pkg::PERIOD_W-1:0]  remainder
);
	import swc_pkg::*;

	localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DVD_W - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]     dvd_q;     // dividend shifts out, quotient shifts in
	logic [PERIOD_W-1:0]  dsr_q;
	logic [PERIOD_W-1:0]  rem_q;

	logic [DVD_W-1:0] rem_sh;
	logic [DVD_W-1:0] diff;
	logic             ge;

	// Shared subtract and compare
	always_comb begin
		rem_sh = {rem_q, dvd_q[DVD_W-1]};
		diff   = rem_sh - {1'b0, dsr_q};
		ge     = rem_sh >= {1'b0, dsr_q};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < dsr_q)
		else $error("remainder not below divisor");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("done without a division");

endmodule

@@ rtl/square_wave_channel.sv @@
// Top level of the square wave channel: channel registers, envelope,
// sweep, length counter and duty sequencer. Uses swc_pkg and swc_div.
//
//  port group   dir  handshake          payload
//  in_*         in   in_valid/in_ready  in_item  (swc_pkg::in_item_t)
//  out_*        out  out_valid/out_ready out_item (swc_pkg::out_item_t)
//  cfg_*        in   cfg_wr_en          cfg_wr_data (second_channel)
//
// Register, enable, quarter and half frame items go from accept straight to the
// result state. A timer tick first runs the divider over all 13 quotient bits,
// then loads the result; with a zero period it skips the divider.
// An item is accepted while the previous result still waits on out_*;
// the next result load waits for the output register to free up.
// Reset clears all channel state to zero; no clearing pass.
module square_wave_channel (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  swc_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output swc_pkg::out_item_t  out_item,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data
);
	import swc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_POST = 2'd2;

	logic [1:0] state_q;
	logic       second_q;

	// Channel state
	logic [1:0]          duty_q;
	logic                halt_q;
	logic                env_on_q;
	logic [4:0]          env_period_q;
	logic [4:0]          env_div_q;
	logic [3:0]          env_level_q;
	logic                env_restart_q;
	logic [3:0]          vol_now_q;
	logic [3:0]          vol_fixed_q;
	logic [7:0]          sweep_q;
	logic [3:0]          sweep_div_q;
	logic                sweep_reload_q;
	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] count_q;
	logic                half_q;
	logic [2:0]          step_q;
	logic [7:0]          length_q;
	logic                channel_on_q;
	logic [3:0]          dac_q;

	logic       out_valid_q;
	out_item_t  out_item_q;

	logic accept;
	logic load_out;
	logic div_start;
	logic div_done;
	logic [DVD_W-1:0]    div_q;
	logic [PERIOD_W-1:0] div_rem;
	logic [DVD_W-1:0]    dividend;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign load_out = (state_q == ST_POST) && (!out_valid_q || out_ready);
	assign dividend = {1'b0, count_q} + DVD_W'(in_item.sample_ticks);
	assign div_start = accept && (in_item.operation == OP_TICK) && (period_q != '0);

	swc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (dividend),
		.divisor   (period_q),
		.done      (div_done),
		.quotient  (div_q),
		.remainder (div_rem)
	);

	// Envelope step
	logic [4:0] env_div_inc;
	logic [4:0] env_div_n;
	logic [3:0] env_level_n;
	logic       env_edge;
	always_comb begin
		env_div_inc = env_div_q + 1'b1;
		env_edge    = 1'b0;
		env_div_n   = env_div_inc;
		env_level_n = env_level_q;
		if (env_restart_q) begin
			env_div_n   = '0;
			env_level_n = VOL_MAX;
		end else if (env_div_inc >= env_period_q) begin
			env_div_n = '0;
			env_edge  = 1'b1;
		end
		if (env_edge) begin
			if (halt_q && env_level_q == '0)
				env_level_n = VOL_MAX;
			else if (env_level_q != '0)
				env_level_n = env_level_q - 1'b1;
		end
	end

	// Sweep step: target period and divider
	logic [PERIOD_W-1:0] sw_shifted;
	logic [13:0]         sw_target;
	logic [3:0]          sw_div_inc;
	logic [3:0]          sw_div_n;
	logic                sw_edge;
	logic                sw_mute;
	logic                sw_en;
	always_comb begin
		sw_en      = sweep_q[7];
		sw_shifted = period_q >> sweep_q[2:0];
		if (!sw_en)
			sw_target = '0;
		else if (sweep_q[3])
			sw_target = {2'b00, period_q} + ~{2'b00, sw_shifted} + 14'(second_q);
		else
			sw_target = {2'b00, period_q} + {2'b00, sw_shifted};
		sw_mute    = (period_q < PERIOD_MIN) ||
		             (!sw_target[13] && (sw_target > SWEEP_LIMIT));
		sw_div_inc = sweep_div_q + 1'b1;
		sw_edge    = sw_div_inc >= ({1'b0, sweep_q[6:4]} + 4'd1);
		sw_div_n   = (sw_edge || sweep_reload_q) ? 4'd0 : sw_div_inc;
	end

	// Tick finish: advance sequencer by half the divider edges
	logic [3:0]       tk_edges;
	logic [3:0]       tk_h;
	logic [2:0]       tk_step;
	logic             tk_play;
	assign tk_edges = (state_q == ST_DIV) ? div_q[3:0] : 4'd0;
	assign tk_h     = {3'b000, half_q} + tk_edges;
	assign tk_step  = step_q + tk_h[3:1];
	assign tk_play  = channel_on_q && (length_q != '0);
	logic tk_finish;
	assign tk_finish = (state_q == ST_DIV && div_done) ||
	                   (accept && in_item.operation == OP_TICK && period_q == '0);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= div_start ? ST_DIV : ST_POST;
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_POST;
				end
				ST_POST: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			second_q <= 1'b0;
		else if (cfg_wr_en)
			second_q <= cfg_wr_data;
	end

	// Channel state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q         <= '0;
			halt_q         <= 1'b0;
			env_on_q       <= 1'b0;
			env_period_q   <= '0;
			env_div_q      <= '0;
			env_level_q    <= '0;
			env_restart_q  <= 1'b0;
			vol_now_q      <= '0;
			vol_fixed_q    <= '0;
			sweep_q        <= '0;
			sweep_div_q    <= '0;
			sweep_reload_q <= 1'b0;
			period_q       <= '0;
			count_q        <= '0;
			half_q         <= 1'b0;
			step_q         <= '0;
			length_q       <= '0;
			channel_on_q   <= 1'b0;
			dac_q          <= '0;
		end else begin
			if (accept) begin
				case (in_item.operation)
					OP_REG_WRITE: begin
						unique case (in_item.reg_index)
							REG_CTRL: begin
								duty_q       <= in_item.write_data[7:6];
								halt_q       <= in_item.write_data[5];
								env_on_q     <= !in_item.write_data[4];
								env_period_q <= {1'b0, in_item.write_data[3:0]} + 5'd1;
								vol_now_q    <= in_item.write_data[3:0];
								vol_fixed_q  <= in_item.write_data[3:0];
							end
							REG_SWEEP: begin
								sweep_q        <= in_item.write_data;
								sweep_reload_q <= 1'b1;
							end
							REG_TIMER_LO: begin
								period_q[7:0] <= in_item.write_data;
							end
							REG_TIMER_HI: begin
								if (channel_on_q)
									length_q <= LENGTH_TABLE[in_item.write_data[7:3]];
								period_q      <= {1'b0, in_item.write_data[2:0], period_q[7:0]}
								                 + 12'd1;
								env_restart_q <= 1'b1;
								step_q        <= '0;
							end
							default: ;
						endcase
					end
					OP_ENABLE: begin
						channel_on_q <= in_item.enable_bit;
						if (!in_item.enable_bit)
							length_q <= '0;
					end
					OP_QUARTER: begin
						env_restart_q <= 1'b0;
						env_div_q     <= env_div_n;
						env_level_q   <= env_level_n;
						vol_now_q     <= env_on_q ? env_level_n : vol_fixed_q;
					end
					OP_HALF: begin
						if (!halt_q && length_q != '0)
							length_q <= length_q - 1'b1;
						sweep_div_q    <= sw_div_n;
						sweep_reload_q <= 1'b0;
						if (sw_mute)
							vol_now_q <= 4'd0;
						else if (sw_en && sweep_q[2:0] != 3'd0 && sw_edge)
							period_q <= {1'b0, sw_target[10:0]};
					end
					default: ;
				endcase
			end
			// Timer tick result
			if (tk_finish) begin
				if (state_q == ST_DIV)
					count_q <= div_rem;
				if (tk_play) begin
					half_q <= tk_h[0];
					step_q <= tk_step;
					dac_q  <= duty_bit(duty_q, tk_step) ? vol_now_q : 4'd0;
				end else begin
					dac_q <= 4'd0;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_item_q.dac_level     <= dac_q;
			out_item_q.length_active <= (length_q != '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside a timer tick");
	a_off_no_length: assert property (@(posedge clk) disable iff (!arst_n)
		!channel_on_q |-> length_q == '0)
		else $error("length counter running on a disabled channel");
	a_load_from_post: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_POST)
		else $error("result loaded outside result state");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |=> !accept || $past(div_done))
		else $error("item accepted during a division");

endmodule
